### rtl/spq_pkg.sv
// spq_pkg: shared types and constants for the sorted priority queue
// no dependencies
`timescale 1ns / 1ps

package spq_pkg;

  localparam int Capacity    = 64;
  localparam int PayloadBits = 16;
  localparam int AddrBits    = $clog2(Capacity);
  localparam int CountBits   = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_POP    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [31:0]            key;
    logic [PayloadBits-1:0] payload;
  } entry_t;

endpackage

### rtl/spq_ram.sv
// spq_ram: single write port, single read port entry memory, registered read data
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_ram (
  input  logic                    clk,
  input  logic                    we,
  input  logic [spq_pkg::AddrBits-1:0] waddr,
  input  spq_pkg::entry_t         wdata,
  input  logic [spq_pkg::AddrBits-1:0] raddr,
  output spq_pkg::entry_t         rdata
);
  import spq_pkg::*;

  entry_t mem [Capacity];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sorted_priority_queue_unit.sv
// sorted_priority_queue_unit: top level of the key-ordered queue
// depends on spq_pkg and spq_ram
`timescale 1ns / 1ps

// sequence: a refused insert or a pop on empty goes straight from idle to the result; otherwise a scan
//   reads the entries in order, then for insert, delete or pop a shift moves the tail by one slot
// throughput: one transaction at a time, set by the sequential walk of the entry memory
// busy is high from accept until the result strobe
// reset: synchronous active-low rst_n empties the queue, memory contents are kept
// the receiver cannot stall: out_valid is a single-cycle strobe

module sorted_priority_queue_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_key,
  input  logic [15:0] in_payload_in,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_key_out,
  output logic [15:0] out_payload_out,
  output logic [6:0]  out_entry_count
);
  import spq_pkg::*;

  fsm_t state_r, state_nxt;
  req_t req_r;
  logic [31:0] key_r;
  logic [PayloadBits-1:0] pl_r;
  logic [CountBits-1:0] count_r, count_nxt;
  // scan / shift index; rd_pend_r marks that rdata holds the entry just read (idx_r, or idx_r-1 in shift up)
  logic [CountBits-1:0] idx_r, idx_nxt;
  logic rd_pend_r, rd_pend_nxt;
  logic [1:0] st_r, st_nxt;
  logic [31:0] ko_r, ko_nxt;
  logic [PayloadBits-1:0] po_r, po_nxt;
  logic [CountBits-1:0] slot_r, slot_nxt;

  logic we;
  logic [AddrBits-1:0] waddr, raddr;
  entry_t wdata, rdata;

  spq_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
    idx_r  <= idx_nxt;
    st_r   <= st_nxt;
    ko_r   <= ko_nxt;
    po_r   <= po_nxt;
    slot_r <= slot_nxt;
    if (state_r == S_IDLE && start) begin
      req_r <= req_t'(in_req_type);
      key_r <= in_key;
      pl_r  <= in_payload_in[PayloadBits-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    rd_pend_nxt = 1'b0;
    st_nxt      = st_r;
    ko_nxt      = ko_r;
    po_nxt      = po_r;
    slot_nxt    = slot_r;
    we          = 1'b0;
    waddr       = idx_r[AddrBits-1:0];
    wdata       = rdata;
    raddr       = idx_r[AddrBits-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          st_nxt  = ST_OK;
          ko_nxt  = '0;
          po_nxt  = '0;
          idx_nxt = '0;
          if (req_t'(in_req_type) == REQ_INSERT && count_r == CountBits'(Capacity)) begin
            st_nxt    = ST_FULL;
            state_nxt = S_DONE;
          end else if (req_t'(in_req_type) == REQ_POP && count_r == '0) begin
            st_nxt    = ST_NOTFOUND;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue read of idx_r, examine on next cycle
        if (!rd_pend_r) begin
          if (idx_r == count_r) begin
            // ran off the end
            if (req_r == REQ_INSERT) begin
              we        = 1'b1;
              wdata     = '{key: key_r, payload: pl_r};
              count_nxt = count_r + 1'b1;
              state_nxt = S_DONE;
            end else begin
              st_nxt    = ST_NOTFOUND;
              state_nxt = S_DONE;
            end
          end else begin
            rd_pend_nxt = 1'b1;
          end
        end else if (req_r == REQ_POP || rdata.key >= key_r) begin
          slot_nxt = idx_r;
          if (req_r == REQ_INSERT) begin
            // shift tail up starting from last entry
            idx_nxt   = count_r;
            state_nxt = S_SHIFT_UP;
          end else if (req_r != REQ_POP && rdata.key != key_r) begin
            st_nxt    = ST_NOTFOUND;
            state_nxt = S_DONE;
          end else begin
            ko_nxt = rdata.key;
            po_nxt = rdata.payload;
            if (req_r == REQ_SEARCH) begin
              state_nxt = S_DONE;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_SHIFT_DOWN;
            end
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SHIFT_UP: begin
        // idx_r is destination; copy idx_r-1 into it
        if (idx_r == slot_r) begin
          we        = 1'b1;
          wdata     = '{key: key_r, payload: pl_r};
          count_nxt = count_r + 1'b1;
          state_nxt = S_DONE;
        end else if (!rd_pend_r) begin
          raddr       = AddrBits'(idx_r - 1'b1);
          rd_pend_nxt = 1'b1;
        end else begin
          we      = 1'b1;
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_SHIFT_DOWN: begin
        // idx_r is source; copy into idx_r-1
        if (idx_r == count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end else if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else begin
          we      = 1'b1;
          waddr   = AddrBits'(idx_r - 1'b1);
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_DONE);
  assign out_status      = st_r;
  assign out_key_out     = ko_r;
  assign out_payload_out = 16'(po_r);
  assign out_entry_count = 7'(count_r);

  // count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CountBits'(Capacity)) else $error("count over capacity");
  // a refused insert leaves count unchanged
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && st_r == ST_FULL |-> $stable(count_r)) else $error("full insert changed count");
  // failed results (not found or full) carry zero key
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && st_r != ST_OK |-> ko_r == '0) else $error("nonzero key on failure");
  // a result is followed by idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");

endmodule

### sim/tb_sorted_priority_queue_unit.sv
// tb_sorted_priority_queue_unit: self-checking testbench for the sorted priority queue
// depends on spq_pkg and sorted_priority_queue_unit
`timescale 1ns / 1ps

module tb_sorted_priority_queue_unit;
  import spq_pkg::*;

  // ordered key/payload store plus the queue of expected responses
  class queue_scoreboard;
    logic [31:0] keys[$];
    logic [15:0] pays[$];
    logic [1:0]  exp_status[$];
    logic [31:0] exp_key[$];
    logic [15:0] exp_pay[$];
    logic [6:0]  exp_count[$];
    int          mismatches;

    function int held();
      return keys.size();
    endfunction

    // first slot whose key is not below k
    function int lower_slot(logic [31:0] k);
      int i;
      i = 0;
      while (i < keys.size() && keys[i] < k) i++;
      return i;
    endfunction

    // apply one accepted request to the store and queue its expected response
    function void note_request(req_t req, logic [31:0] k, logic [15:0] pl);
      status_t     st;
      logic [31:0] ko;
      logic [15:0] po;
      int          s;
      st = ST_OK;
      ko = '0;
      po = '0;
      case (req)
        REQ_INSERT: begin
          if (keys.size() >= Capacity) begin
            st = ST_FULL;
          end else begin
            s = lower_slot(k);
            keys.insert(s, k);
            pays.insert(s, pl);
          end
        end
        REQ_DELETE, REQ_SEARCH: begin
          s = lower_slot(k);
          if (s >= keys.size() || keys[s] != k) begin
            st = ST_NOTFOUND;
          end else begin
            ko = keys[s];
            po = pays[s];
            if (req == REQ_DELETE) begin
              keys.delete(s);
              pays.delete(s);
            end
          end
        end
        default: begin
          if (keys.size() == 0) begin
            st = ST_NOTFOUND;
          end else begin
            ko = keys.pop_front();
            po = pays.pop_front();
          end
        end
      endcase
      exp_status.push_back(st);
      exp_key.push_back(ko);
      exp_pay.push_back(po);
      exp_count.push_back(7'(keys.size()));
    endfunction

    function void check_response(logic [1:0] st, logic [31:0] ko, logic [15:0] po,
                                 logic [6:0] cnt);
      logic [1:0]  es;
      logic [31:0] ek;
      logic [15:0] ep;
      logic [6:0]  ec;
      if (exp_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response st=%0d key=%h", st, ko);
        return;
      end
      es = exp_status.pop_front();
      ek = exp_key.pop_front();
      ep = exp_pay.pop_front();
      ec = exp_count.pop_front();
      if (st !== es || ko !== ek || po !== ep || cnt !== ec) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d key=%h pay=%h cnt=%0d, got st=%0d key=%h pay=%h cnt=%0d",
                   es, ek, ep, ec, st, ko, po, cnt);
      end
    endfunction

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [31:0] in_key;
  logic [15:0] in_payload_in;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_key_out;
  logic [15:0] out_payload_out;
  logic [6:0]  out_entry_count;

  queue_scoreboard sb;
  int              idle_pct;
  logic [31:0]     key_pool[$];

  sorted_priority_queue_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .in_payload_in  (in_payload_in),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_key_out    (out_key_out),
    .out_payload_out(out_payload_out),
    .out_entry_count(out_entry_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // responses are single-cycle strobes, sampled at the edge that ends them
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_response(out_status, out_key_out, out_payload_out, out_entry_count);
  end

  // drive one transaction: random idle gap first, then hold start until accepted
  task automatic send_request(req_t req, logic [31:0] k, logic [15:0] pl);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start         <= 1'b1;
    in_req_type   <= req;
    in_key        <= k;
    in_payload_in <= pl;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    sb.note_request(req, k, pl);
    start <= 1'b0;
    // wait for the response before the next command so busy is stable
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // keys drawn mostly from a small pool so hits and duplicates are common
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 70 && key_pool.size() > 0) return key_pool[$urandom_range(key_pool.size() - 1)];
    if (r < 80) return 32'hFFFF_FFFF;
    if (r < 85) return 32'h0;
    return $urandom();
  endfunction

  task automatic random_phase(int n);
    int   r;
    req_t req;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      // bias toward fill or drain depending on how full the queue is
      if (sb.held() < 32) req = (r < 50) ? REQ_INSERT : (r < 65) ? REQ_DELETE :
                                (r < 85) ? REQ_SEARCH : REQ_POP;
      else req = (r < 30) ? REQ_INSERT : (r < 55) ? REQ_DELETE :
                 (r < 75) ? REQ_SEARCH : REQ_POP;
      send_request(req, pick_key(), 16'($urandom()));
    end
  endtask

  initial begin
    sb            = new();
    idle_pct      = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req_type   = REQ_INSERT;
    in_key        = '0;
    in_payload_in = '0;
    for (int i = 0; i < 12; i++) key_pool.push_back($urandom());
    key_pool.push_back(32'h5);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, misses on empty, extremes, duplicates and ordering
    send_request(REQ_POP, 32'h0, 16'h0);
    send_request(REQ_SEARCH, 32'h5, 16'h0);
    send_request(REQ_DELETE, 32'h5, 16'h0);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(REQ_INSERT, 32'h0, 16'h0000);
    send_request(REQ_INSERT, 32'h5, 16'hAAAA);
    send_request(REQ_INSERT, 32'h5, 16'h5555);   // equal key goes in front
    send_request(REQ_SEARCH, 32'h5, 16'h0);
    send_request(REQ_SEARCH, 32'h6, 16'h0);
    send_request(REQ_DELETE, 32'h5, 16'h0);
    send_request(REQ_SEARCH, 32'hFFFF_FFFF, 16'h0);
    send_request(REQ_POP, 32'h0, 16'h0);
    send_request(REQ_POP, 32'h0, 16'h0);
    send_request(REQ_POP, 32'h0, 16'h0);
    send_request(REQ_POP, 32'h0, 16'h0);

    // fill to capacity and try twice more to hit the full case
    for (int i = 0; i < Capacity + 2; i++)
      send_request(REQ_INSERT, $urandom(), 16'($urandom()));
    for (int i = 0; i < 6; i++) send_request(REQ_POP, 32'h0, 16'h0);

    idle_pct = 29;
    random_phase(280);
    idle_pct = 72;
    random_phase(280);
    idle_pct = 0;
    random_phase(300);

    // drain
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
